>>> rtl/grid_raycast_column_renderer_unit_defines.svh
// assertion macros for the grid raycast column renderer
// used by the modules that check their own control logic
`ifndef GRID_RAYCAST_COLUMN_RENDERER_UNIT_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_RENDERER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GRC_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define GRC_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define GRC_ASSERT_IMPLY(label, clk, rst, a, b)
`define GRC_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> rtl/grc_pkg.sv
// shared types, constants and the sine table of the column renderer
// no dependencies
package grc_pkg;

   localparam int MAP_SIZE  = 16;
   localparam int MAX_DEPTH = 16;
   localparam int MAX_ROWS  = 64;

   localparam logic [15:0] DEPTH_FX  = 16'(MAX_DEPTH * 2048);
   localparam logic [15:0] STEP_FX   = 16'd205;
   localparam logic [15:0] NEAR_FX   = 16'd4096;
   localparam logic [20:0] EDGE_COS2 = 21'd1048471;

   // register indexes
   localparam logic [2:0] REG_WALL_A = 3'd0;
   localparam logic [2:0] REG_WALL_B = 3'd1;
   localparam logic [2:0] REG_WALL_C = 3'd2;
   localparam logic [2:0] REG_WALL_D = 3'd3;
   localparam logic [2:0] REG_VIEW_W = 3'd4;
   localparam logic [2:0] REG_VIEW_H = 3'd5;
   localparam logic [2:0] REG_FOV    = 3'd6;

   // glyph codes
   localparam logic [3:0] GLYPH_BLANK  = 4'd0;
   localparam logic [3:0] GLYPH_FULL   = 4'd1;
   localparam logic [3:0] GLYPH_DARK   = 4'd2;
   localparam logic [3:0] GLYPH_MEDIUM = 4'd3;
   localparam logic [3:0] GLYPH_LIGHT  = 4'd4;
   localparam logic [3:0] GLYPH_EDGE   = 4'd5;
   localparam logic [3:0] GLYPH_HASH   = 4'd6;
   localparam logic [3:0] GLYPH_X      = 4'd7;
   localparam logic [3:0] GLYPH_DOT    = 4'd8;
   localparam logic [3:0] GLYPH_DASH   = 4'd9;
   localparam logic [3:0] GLYPH_BAR    = 4'd10;

   typedef struct packed {
      logic [3:0][63:0] walls;
      logic [7:0]       view_w;   // never zero
      logic [6:0]       view_h;   // clamped to 2..MAX_ROWS
      logic [14:0]      fov;
   } cfg_type;

   // one column job handed from the ray caster to the row emitter
   typedef struct packed {
      logic [6:0] rows;
      logic [5:0] ceil_row;
      logic [3:0] shade;
   } job_type;

   localparam logic [14:0] QUARTER_SINE [0:32] = '{
      15'd0, 15'd804, 15'd1606, 15'd2404, 15'd3196, 15'd3981, 15'd4756, 15'd5520,
      15'd6270, 15'd7005, 15'd7723, 15'd8423, 15'd9102, 15'd9760, 15'd10394,
      15'd11003, 15'd11585, 15'd12140, 15'd12665, 15'd13160, 15'd13623,
      15'd14053, 15'd14449, 15'd14811, 15'd15137, 15'd15426, 15'd15679,
      15'd15893, 15'd16069, 15'd16207, 15'd16305, 15'd16364, 15'd16384
   };

   // q1.14 sine of a turn fraction, quarter table with truncated interpolation
   function automatic logic signed [15:0] sine_q14(logic [15:0] a);
      logic [14:0] r;
      logic [5:0]  idx;
      logic [8:0]  frac;
      logic [14:0] lo;
      logic [14:0] hi;
      logic [18:0] prod;
      logic [14:0] v;
      r = {1'b0, a[13:0]};
      if (a[14]) begin
         r = 15'd16384 - r;
      end
      idx  = r[14:9];
      frac = r[8:0];
      lo   = 15'd0;
      hi   = 15'd0;
      prod = 19'd0;
      if (idx[5]) begin
         v = QUARTER_SINE[32];
      end else begin
         lo   = QUARTER_SINE[idx];
         hi   = QUARTER_SINE[6'(idx + 6'd1)];
         prod = 19'(hi - lo) * 19'(frac);
         v    = lo + 15'(prod >> 9);
      end
      return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

endpackage

>>> rtl/grid_raycast_column_renderer_unit.sv
// Grid raycast column renderer, top level.
// Depends on grc_pkg, grc_front, grc_queue and grc_back.
//
// Usage: write the map rows and view settings on the csr port while idle,
// then send one column per transaction on req (column, position, heading).
// For every column the block sends view_height transactions on rsp, one per
// screen row from the top, with tlast on the final row.
// The ray caster accepts a column, then runs the angle division, the sine lookup
// and setup, the march one step at a time, the corner test on a wall hit, the
// ceiling setup and division and the job handover; its time per column is set by
// the march loop and the shared multiplier of the corner test. The row emitter
// picks up each job and sends one row per cycle while rsp is ready, overlapped
// with the next cast through a two-job queue. The first row passes through the
// queue, the job register and the output register after the cast ends. Reset
// loads the register defaults and empties all stages.
// When rsp stalls, rows wait in the output register, the queue fills and
// req_tready then stays low until the queue has room again.
module grid_raycast_column_renderer_unit
   import grc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // column[7:0], pos_x[23:8], pos_y[39:24], heading[55:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // row[5:0], glyph[9:6], zero[15:10]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   logic [3:0][63:0] walls_ff;
   logic [7:0]  view_w_ff;
   logic [6:0]  view_h_ff;
   logic [14:0] fov_ff;
   cfg_type     cfg;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         walls_ff  <= '0;
         view_w_ff <= 8'd120;
         view_h_ff <= 7'd40;
         fov_ff    <= 15'd8192;
      end else if (csr_we) begin
         case (csr_addr)
            REG_WALL_A: walls_ff[0] <= csr_wdata;
            REG_WALL_B: walls_ff[1] <= csr_wdata;
            REG_WALL_C: walls_ff[2] <= csr_wdata;
            REG_WALL_D: walls_ff[3] <= csr_wdata;
            REG_VIEW_W: view_w_ff   <= csr_wdata[7:0];
            REG_VIEW_H: view_h_ff   <= csr_wdata[6:0];
            REG_FOV:    fov_ff      <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // effective view settings
   always_comb begin
      cfg.walls  = walls_ff;
      cfg.view_w = (view_w_ff == 8'd0) ? 8'd1 : view_w_ff;
      cfg.fov    = fov_ff;
      if (view_h_ff < 7'd2) cfg.view_h = 7'd2;
      else if (view_h_ff > 7'(MAX_ROWS)) cfg.view_h = 7'(MAX_ROWS);
      else cfg.view_h = view_h_ff;
   end

   logic    push, full, pop, not_empty;
   job_type push_job, pop_job;
   logic [5:0] out_row;
   logic [3:0] out_glyph;

   grc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_column  (req_tdata[7:0]),
      .in_pos_x   (req_tdata[23:8]),
      .in_pos_y   (req_tdata[39:24]),
      .in_heading (req_tdata[55:40]),
      .job_push   (push),
      .job        (push_job),
      .queue_full (full)
   );

   grc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (pop),
      .pop_job   (pop_job),
      .not_empty (not_empty)
   );

   grc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (not_empty),
      .job       (pop_job),
      .job_pop   (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_row   (out_row),
      .out_glyph (out_glyph),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, out_glyph, out_row};

endmodule

>>> rtl/grc_front.sv
// ray caster: angle division, sine lookup, march, corner edge test, ceiling
// depends on grc_pkg
module grc_front
   import grc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  in_column,
   input  logic [15:0] in_pos_x,
   input  logic [15:0] in_pos_y,
   input  logic [15:0] in_heading,
   output logic        job_push,
   output job_type     job,
   input  logic        queue_full
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV   = 4'd1;
   localparam logic [3:0] S_SIN   = 4'd2;
   localparam logic [3:0] S_COS   = 4'd3;
   localparam logic [3:0] S_PREP  = 4'd4;
   localparam logic [3:0] S_MARCH = 4'd5;
   localparam logic [3:0] S_EDGE  = 4'd6;
   localparam logic [3:0] S_EFIN  = 4'd7;
   localparam logic [3:0] S_CSET  = 4'd8;
   localparam logic [3:0] S_PUSH  = 4'd9;

   localparam logic [3:0] E_LAST = 4'd9;

   logic [3:0] state_ff, state_in;

   logic [15:0] px_ff, py_ff, head_ff, ang_ff, dist_ff;
   logic [6:0]  rows_ff;
   logic signed [15:0] ex_ff, ey_ff;
   logic signed [23:0] stx_ff, sty_ff;
   logic signed [31:0] sx_ff, sy_ff;
   logic [3:0]  cx_ff, cy_ff;
   logic [1:0]  k_ff, far_ff;
   logic [3:0]  s_ff, near_ff;
   logic signed [35:0] p_ff;
   logic [33:0] d2_ff, best_ff;
   logic [63:0] pp_ff, rhs_ff;
   logic        edge_ff, ceil_mode_ff;
   logic [5:0]  ceil_ff;

   // shared restoring divider
   logic [22:0] dvd_ff;
   logic [16:0] rem_ff, den_ff;
   logic [4:0]  cnt_ff;
   logic [17:0] trial;
   logic        qbit;
   logic [22:0] dvd_in;
   logic [16:0] rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[22]};
      qbit   = trial >= {1'b0, den_ff};
      rem_in = qbit ? 17'(trial - {1'b0, den_ff}) : trial[16:0];
      dvd_in = {dvd_ff[21:0], qbit};
   end

   // one march step
   logic signed [31:0] nsx, nsy;
   logic [15:0] ndist;
   logic        outside, wall_hit;
   logic [3:0]  ncx, ncy;
   logic [63:0] wrow;

   always_comb begin
      nsx     = sx_ff + 32'(stx_ff);
      nsy     = sy_ff + 32'(sty_ff);
      ndist   = dist_ff + STEP_FX;
      outside = nsx[31] || nsy[31] || (nsx[30:29] != 2'b00) || (nsy[30:29] != 2'b00);
      ncx     = nsx[28:25];
      ncy     = nsy[28:25];
      wrow    = cfg.walls[ncy[3:2]];
      wall_hit = wrow[{ncy[1:0], ncx}];
   end

   // corner offset and shared multiplier for the edge test
   logic signed [17:0] vx, vy;
   logic signed [20:0] mul_a, mul_b;
   logic signed [41:0] prod;

   always_comb begin
      vx = $signed({1'b0, 5'({1'b0, cx_ff} + 5'(k_ff[1])), 12'd0}) - $signed({2'b00, px_ff});
      vy = $signed({1'b0, 5'({1'b0, cy_ff} + 5'(k_ff[0])), 12'd0}) - $signed({2'b00, py_ff});
      case (s_ff)
         4'd0: begin mul_a = 21'(ex_ff); mul_b = 21'(vx); end
         4'd1: begin mul_a = 21'(ey_ff); mul_b = 21'(vy); end
         4'd2: begin mul_a = 21'(vx); mul_b = 21'(vx); end
         4'd3: begin mul_a = 21'(vy); mul_b = 21'(vy); end
         4'd4: begin mul_a = {4'd0, p_ff[16:0]}; mul_b = {4'd0, p_ff[16:0]}; end
         4'd5: begin mul_a = {4'd0, p_ff[16:0]}; mul_b = {6'd0, p_ff[31:17]}; end
         4'd6: begin mul_a = {6'd0, p_ff[31:17]}; mul_b = {6'd0, p_ff[31:17]}; end
         4'd7: begin mul_a = {4'd0, d2_ff[16:0]}; mul_b = $signed(EDGE_COS2); end
         4'd8: begin mul_a = {4'd0, d2_ff[33:17]}; mul_b = $signed(EDGE_COS2); end
         default: begin mul_a = 21'sd0; mul_b = 21'sd0; end
      endcase
      prod = mul_a * mul_b;
   end

   // wall shade from the saturated distance
   logic [3:0] shade;
   always_comb begin
      if ({2'b00, dist_ff} * 18'd4 <= 18'(DEPTH_FX)) shade = GLYPH_FULL;
      else if ({2'b00, dist_ff} * 18'd3 < 18'(DEPTH_FX)) shade = GLYPH_DARK;
      else if ({1'b0, dist_ff} * 17'd2 < 17'(DEPTH_FX)) shade = GLYPH_MEDIUM;
      else if (dist_ff < DEPTH_FX) shade = GLYPH_LIGHT;
      else shade = GLYPH_BLANK;
      if (edge_ff) shade = GLYPH_EDGE;
   end

   assign in_ready      = (state_ff == S_IDLE);
   assign job_push      = (state_ff == S_PUSH) && !queue_full;
   assign job.rows      = rows_ff;
   assign job.ceil_row  = ceil_ff;
   assign job.shade     = shade;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (in_valid) state_in = S_DIV;
         S_DIV:   if (cnt_ff == 5'd0) state_in = ceil_mode_ff ? S_PUSH : S_SIN;
         S_SIN:   state_in = S_COS;
         S_COS:   state_in = S_PREP;
         S_PREP:  state_in = S_MARCH;
         S_MARCH: begin
            if (outside || (!wall_hit && ndist >= DEPTH_FX)) state_in = S_CSET;
            else if (wall_hit) state_in = S_EDGE;
         end
         S_EDGE:  if (s_ff == E_LAST && k_ff == 2'd3) state_in = S_EFIN;
         S_EFIN:  state_in = S_CSET;
         S_CSET:  state_in = (dist_ff > NEAR_FX) ? S_DIV : S_PUSH;
         S_PUSH:  if (!queue_full) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               px_ff        <= in_pos_x;
               py_ff        <= in_pos_y;
               head_ff      <= in_heading;
               rows_ff      <= cfg.view_h;
               dvd_ff       <= 23'(in_column) * 23'(cfg.fov);
               rem_ff       <= 17'd0;
               den_ff       <= 17'(cfg.view_w);
               cnt_ff       <= 5'd22;
               ceil_mode_ff <= 1'b0;
               edge_ff      <= 1'b0;
               ceil_ff      <= 6'd0;
            end
         end
         S_DIV: begin
            dvd_ff <= dvd_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               ang_ff  <= 16'(head_ff - 16'(cfg.fov >> 1) + dvd_in[15:0]);
               ceil_ff <= dvd_in[5:0];
            end
         end
         S_SIN: ex_ff <= sine_q14(ang_ff);
         S_COS: ey_ff <= sine_q14(16'(ang_ff + 16'h4000));
         S_PREP: begin
            stx_ff  <= 24'(ex_ff) * 24'(STEP_FX);
            sty_ff  <= 24'(ey_ff) * 24'(STEP_FX);
            sx_ff   <= $signed({3'd0, px_ff, 13'd0});
            sy_ff   <= $signed({3'd0, py_ff, 13'd0});
            dist_ff <= 16'd0;
         end
         S_MARCH: begin
            sx_ff   <= nsx;
            sy_ff   <= nsy;
            cx_ff   <= ncx;
            cy_ff   <= ncy;
            k_ff    <= 2'd0;
            s_ff    <= 4'd0;
            // leaving the map or running out of depth saturates the distance
            if (outside || ndist > DEPTH_FX) dist_ff <= DEPTH_FX;
            else dist_ff <= ndist;
         end
         S_EDGE: begin
            s_ff <= s_ff + 4'd1;
            case (s_ff)
               4'd0: p_ff  <= 36'(prod);
               4'd1: p_ff  <= p_ff + 36'(prod);
               4'd2: d2_ff <= 34'(prod);
               4'd3: d2_ff <= d2_ff + 34'(prod);
               4'd4: pp_ff <= 64'(prod);
               4'd5: pp_ff <= pp_ff + (64'(prod) << 18);
               4'd6: pp_ff <= pp_ff + (64'(prod) << 34);
               4'd7: rhs_ff <= 64'(prod) << 8;
               4'd8: rhs_ff <= rhs_ff + (64'(prod) << 25);
               default: begin
                  // close this corner, track the farthest one
                  near_ff[k_ff] <= (p_ff > 36'sd0) && (pp_ff > rhs_ff);
                  if (k_ff == 2'd0 || d2_ff >= best_ff) begin
                     best_ff <= d2_ff;
                     far_ff  <= k_ff;
                  end
                  k_ff <= k_ff + 2'd1;
                  s_ff <= 4'd0;
               end
            endcase
         end
         S_EFIN: edge_ff <= |(near_ff & ~(4'b0001 << far_ff));
         S_CSET: begin
            // ceiling = h*(dist-4096) / (2*dist)
            dvd_ff       <= 23'(rows_ff) * 23'(dist_ff - NEAR_FX);
            rem_ff       <= 17'd0;
            den_ff       <= {dist_ff, 1'b0};
            cnt_ff       <= 5'd22;
            ceil_mode_ff <= 1'b1;
            ceil_ff      <= 6'd0;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> rtl/grc_queue.sv
// two-entry job queue between the ray caster and the row emitter
// depends on grc_pkg and the assertion macro header
`include "grid_raycast_column_renderer_unit_defines.svh"
module grc_queue
   import grc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    not_empty
);

   job_type    mem_ff [0:1];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_job   = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   `GRC_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !full || pop)
   `GRC_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, not_empty)
   `GRC_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, not_empty)

endmodule

>>> rtl/grc_back.sv
// row emitter: walks one column job row by row into the output register
// depends on grc_pkg
module grc_back
   import grc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job,
   output logic        job_pop,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [5:0]  out_row,
   output logic [3:0]  out_glyph,
   output logic        out_last
);

   logic       active_ff;
   job_type    cur_ff;
   logic [5:0] y_ff;
   logic       valid_ff;
   logic [5:0] row_ff;
   logic [3:0] glyph_ff;
   logic       last_ff;

   logic [6:0]  yy, rem, floor_row, ceil7;
   logic [11:0] h12, rem12;
   logic [3:0]  glyph;
   logic        is_last, emit;

   // glyph of the current row
   always_comb begin
      yy        = {1'b0, y_ff};
      ceil7     = {1'b0, cur_ff.ceil_row};
      rem       = cur_ff.rows - yy;
      floor_row = cur_ff.rows - ceil7;
      h12       = 12'(cur_ff.rows);
      rem12     = 12'(rem);
      if (yy < ceil7) begin
         glyph = GLYPH_BLANK;
      end else if (yy > ceil7 && yy <= floor_row) begin
         glyph = cur_ff.shade;
      end else if (rem12 * 12'd8 < h12) begin
         glyph = GLYPH_HASH;
      end else if (rem12 * 12'd4 < h12) begin
         glyph = GLYPH_X;
      end else if (rem12 * 12'd8 < h12 * 12'd3) begin
         glyph = GLYPH_DOT;
      end else if (rem12 * 12'd20 < h12 * 12'd9) begin
         glyph = GLYPH_DASH;
      end else begin
         glyph = GLYPH_BAR;
      end
      is_last = (7'(yy + 7'd1) == cur_ff.rows);
      emit    = active_ff && (!valid_ff || out_ready);
   end

   assign job_pop   = !active_ff && job_valid;
   assign out_valid = valid_ff;
   assign out_row   = row_ff;
   assign out_glyph = glyph_ff;
   assign out_last  = last_ff;

   // job walk and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         if (job_pop) begin
            active_ff <= 1'b1;
         end else if (emit && is_last) begin
            active_ff <= 1'b0;
         end
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job;
         y_ff   <= 6'd0;
      end else if (emit) begin
         y_ff <= y_ff + 6'd1;
      end
      if (emit) begin
         row_ff   <= y_ff;
         glyph_ff <= glyph;
         last_ff  <= is_last;
      end
   end

endmodule

>>> tb/grid_raycast_column_renderer_unit_tb.sv
// self-checking testbench of the grid raycast column renderer
// needs grc_pkg and grid_raycast_column_renderer_unit, predicts every screen row itself
`timescale 1ns / 1ps

module grid_raycast_column_renderer_unit_tb;
   import grc_pkg::*;

   localparam int  CYCLE_LIMIT  = 3000000;
   localparam int  SETTLE_WAIT  = 300;
   localparam int  RANDOM_ITEMS = 87;

   typedef struct {
      logic [5:0] row;
      logic [3:0] glyph;
      logic       last_row;
   } screen_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // column[7:0], pos_x[23:8], pos_y[39:24], heading[55:40]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // row[5:0], glyph[9:6], zero[15:10]
   logic        rsp_tlast;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [63:0] csr_wdata;

   // shadow copy of the register file
   logic [63:0] wall_map [0:3];
   int unsigned shadow_view_w;
   int unsigned shadow_view_h;
   int unsigned shadow_fov;

   screen_row_type pending_rows [$];
   int          mismatch_count;
   int          cycle_count;
   int          sender_idle_pct;
   int          receiver_idle_pct;

   grid_raycast_column_renderer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // q1.14 sine from the quarter-wave table, truncated interpolation
   function automatic int ray_sine(int unsigned a);
      int unsigned quad;
      int unsigned r;
      int unsigned idx;
      int unsigned frac;
      int          v;
      a    = a & 32'hFFFF;
      quad = a >> 14;
      r    = a & 32'h3FFF;
      if (quad[0]) begin
         r = 16384 - r;
      end
      idx  = r >> 9;
      frac = r & 32'h1FF;
      if (idx >= 32) begin
         v = int'(QUARTER_SINE[32]);
      end else begin
         v = int'(QUARTER_SINE[idx]) +
             (((int'(QUARTER_SINE[idx + 1]) - int'(QUARTER_SINE[idx])) * int'(frac)) >>> 9);
      end
      return quad[1] ? -v : v;
   endfunction

   function automatic bit cell_is_wall(longint cx, longint cy);
      return wall_map[cy >> 2][((cy & 3) * 16) + cx];
   endfunction

   // a corner other than the farthest lying within about 0.01 rad of the ray
   function automatic bit corner_edge_hit(longint cx, longint cy, longint px, longint py,
                                          longint ex, longint ey);
      longint unsigned d2 [4];
      bit              close_k [4];
      longint          vx;
      longint          vy;
      longint          p;
      int              farthest;
      bit              edge_found;
      farthest   = 0;
      edge_found = 1'b0;
      for (int k = 0; k < 4; k++) begin
         vx = (cx + (k >> 1)) * 4096 - px;
         vy = (cy + (k & 1)) * 4096 - py;
         p  = ex * vx + ey * vy;
         d2[k] = longint'(vx * vx + vy * vy);
         if (p > 0) begin
            close_k[k] = (64'(p) * 64'(p)) > (64'd1048471 * 64'd256 * d2[k]);
         end else begin
            close_k[k] = 1'b0;
         end
      end
      for (int k = 1; k < 4; k++) begin
         if (d2[k] >= d2[farthest]) farthest = k;
      end
      for (int k = 0; k < 4; k++) begin
         if (k != farthest && close_k[k]) edge_found = 1'b1;
      end
      return edge_found;
   endfunction

   // cast the ray of one column and queue the glyph of every screen row
   function automatic void predict_column_rows(int unsigned col, longint px, longint py,
                                               int unsigned head);
      int unsigned vw;
      int unsigned h;
      int unsigned ang;
      longint      ex;
      longint      ey;
      longint      ray_dist;
      longint      depth_fx;
      longint      sx;
      longint      sy;
      longint      num;
      int unsigned ceil_row;
      int unsigned floor_row;
      int unsigned rem;
      logic [3:0]  shade;
      logic [3:0]  g;
      bit          hit;
      bit          edge_found;
      screen_row_type entry;
      vw = (shadow_view_w == 0) ? 1 : shadow_view_w;
      h  = shadow_view_h;
      if (h < 2) h = 2;
      if (h > MAX_ROWS) h = MAX_ROWS;
      depth_fx   = longint'(MAX_DEPTH) * 2048;
      ang = (head - (shadow_fov >> 1) + (col * shadow_fov) / vw) & 32'hFFFF;
      ex  = ray_sine(ang);
      ey  = ray_sine(ang + 32'h4000);
      ray_dist   = 0;
      hit        = 1'b0;
      edge_found = 1'b0;
      // march in fixed steps until a wall, the map border or the depth limit
      while (!hit && ray_dist < depth_fx) begin
         ray_dist = ray_dist + 205;
         sx = px * 8192 + ex * ray_dist;
         sy = py * 8192 + ey * ray_dist;
         if (sx < 0 || sy < 0) begin
            hit      = 1'b1;
            ray_dist = depth_fx;
         end else if ((sx >> 25) >= MAP_SIZE || (sy >> 25) >= MAP_SIZE) begin
            hit      = 1'b1;
            ray_dist = depth_fx;
         end else if (cell_is_wall(sx >> 25, sy >> 25)) begin
            hit        = 1'b1;
            edge_found = corner_edge_hit(sx >> 25, sy >> 25, px, py, ex, ey);
         end
      end
      if (ray_dist > depth_fx) ray_dist = depth_fx;
      num       = longint'(h) * ray_dist - longint'(h) * 4096;
      ceil_row  = (num > 0) ? int'(num / (2 * ray_dist)) : 0;
      floor_row = h - ceil_row;
      if (4 * ray_dist <= depth_fx)      shade = GLYPH_FULL;
      else if (3 * ray_dist < depth_fx)  shade = GLYPH_DARK;
      else if (2 * ray_dist < depth_fx)  shade = GLYPH_MEDIUM;
      else if (ray_dist < depth_fx)      shade = GLYPH_LIGHT;
      else                               shade = GLYPH_BLANK;
      if (edge_found) shade = GLYPH_EDGE;
      for (int unsigned y = 0; y < h; y++) begin
         if (y < ceil_row) begin
            g = GLYPH_BLANK;
         end else if (y > ceil_row && y <= floor_row) begin
            g = shade;
         end else begin
            rem = h - y;
            if (8 * rem < h)            g = GLYPH_HASH;
            else if (4 * rem < h)       g = GLYPH_X;
            else if (8 * rem < 3 * h)   g = GLYPH_DOT;
            else if (20 * rem < 9 * h)  g = GLYPH_DASH;
            else                        g = GLYPH_BAR;
         end
         entry.row      = y[5:0];
         entry.glyph    = g;
         entry.last_row = (y + 1 == h);
         pending_rows.insert(pending_rows.size(), entry);
      end
   endfunction

   // register write, only while the block is idle
   task automatic write_register(logic [2:0] index, logic [63:0] value);
      csr_we    = 1'b1;
      csr_addr  = index;
      csr_wdata = value;
      @(posedge clock);
      case (index)
         REG_WALL_A, REG_WALL_B, REG_WALL_C, REG_WALL_D: begin
            wall_map[index] = value;
         end
         REG_VIEW_W: begin
            shadow_view_w = value[7:0];
         end
         REG_VIEW_H: begin
            shadow_view_h = value[6:0];
         end
         REG_FOV: begin
            shadow_fov = value[14:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // one column transaction, with a random idle gap before it
   task automatic send_column(logic [7:0] col, logic [15:0] px, logic [15:0] py,
                              logic [15:0] head);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {head, py, px, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_column_rows(col, px, py, head);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // wait until every queued row has come back, then let the block settle
   task automatic drain_rows();
      while (pending_rows.size() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic load_map(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] d);
      write_register(REG_WALL_A, a);
      write_register(REG_WALL_B, b);
      write_register(REG_WALL_C, c);
      write_register(REG_WALL_D, d);
   endtask

   // empty map at reset settings: every ray runs off the border or out of depth
   task automatic test_open_map();
      send_column(8'd0, 16'h8000, 16'h8000, 16'h0000);
      send_column(8'd119, 16'h8000, 16'h8000, 16'h4000);
      send_column(8'd254, 16'h0000, 16'h0000, 16'hFFFF);
      send_column(8'd60, 16'hFFFF, 16'hFFFF, 16'h8000);
      send_column(8'd200, 16'h0000, 16'hFFFF, 16'hC000);
      drain_rows();
   endtask

   // walled border with pillars: near walls, far walls and corner edges
   task automatic test_walled_room();
      load_map(64'h8001_8001_8421_FFFF, 64'h8001_8181_8181_8001,
               64'h8001_8001_8C31_8001, 64'hFFFF_8001_8001_8001);
      send_column(8'd60, 16'h8000, 16'h8000, 16'h0000);
      send_column(8'd60, 16'h8000, 16'h8000, 16'h2000);
      send_column(8'd60, 16'h1800, 16'h1800, 16'hA000);
      send_column(8'd0, 16'h2000, 16'hE000, 16'h6000);
      send_column(8'd119, 16'h5000, 16'h2800, 16'hE000);
      send_column(8'd30, 16'h6800, 16'h6800, 16'h5FFF);
      send_column(8'd90, 16'hE800, 16'h3000, 16'h2000);
      drain_rows();
   endtask

   // register extremes: zero width, clamped heights, narrowest and widest view
   task automatic test_register_extremes();
      write_register(REG_VIEW_W, 64'd0);
      write_register(REG_VIEW_H, 64'd0);
      write_register(REG_FOV, 64'd1);
      send_column(8'd0, 16'h8000, 16'h8000, 16'h1000);
      send_column(8'd254, 16'h3000, 16'hB000, 16'h7000);
      drain_rows();
      write_register(REG_VIEW_W, 64'd255);
      write_register(REG_VIEW_H, 64'd127);
      write_register(REG_FOV, 64'd32767);
      send_column(8'd0, 16'h8000, 16'h8000, 16'h0000);
      send_column(8'd254, 16'h8000, 16'h8000, 16'h0000);
      send_column(8'd128, 16'h1400, 16'h1400, 16'hFFFF);
      drain_rows();
      write_register(REG_VIEW_W, 64'd1);
      write_register(REG_VIEW_H, 64'd1);
      send_column(8'd1, 16'h8000, 16'h4000, 16'h3000);
      send_column(8'd255, 16'h4000, 16'h8000, 16'hB000);
      drain_rows();
      write_register(REG_VIEW_H, 64'd64);
      write_register(REG_VIEW_W, 64'd120);
      write_register(REG_FOV, 64'd8192);
      send_column(8'd7, 16'h2100, 16'h2100, 16'h0800);
      drain_rows();
   endtask

   // random map and view, then random columns; most rays start inside free space
   task automatic test_random_views(int s_idle, int r_idle);
      logic [63:0] rows [4];
      logic [7:0]  col;
      logic [15:0] px;
      logic [15:0] py;
      for (int i = 0; i < 4; i++) begin
         rows[i] = {$urandom, $urandom} & {$urandom, $urandom};
      end
      // closed border in half of the runs
      if ($urandom_range(1)) begin
         rows[0] = rows[0] | 64'h8001_8001_8001_FFFF;
         rows[1] = rows[1] | 64'h8001_8001_8001_8001;
         rows[2] = rows[2] | 64'h8001_8001_8001_8001;
         rows[3] = rows[3] | 64'hFFFF_8001_8001_8001;
      end
      load_map(rows[0], rows[1], rows[2], rows[3]);
      write_register(REG_VIEW_W, 64'($urandom_range(255, 1)));
      write_register(REG_VIEW_H, 64'($urandom_range(64, 2)));
      write_register(REG_FOV, 64'($urandom_range(32767, 1)));
      sender_idle_pct   = s_idle;
      receiver_idle_pct = r_idle;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         px  = 16'($urandom);
         py  = 16'($urandom);
         col = (shadow_view_w != 0 && $urandom_range(9) != 0) ?
               8'($urandom_range(shadow_view_w - 1)) : 8'($urandom);
         // mostly from free cells, sometimes from inside a wall
         if ($urandom_range(9) != 0) begin
            for (int tries = 0; tries < 20 && cell_is_wall(px >> 12, py >> 12); tries++) begin
               px = 16'($urandom);
               py = 16'($urandom);
            end
         end
         send_column(col, px, py, 16'($urandom));
         // hold off once, halfway through, until the block is empty
         if (n == RANDOM_ITEMS / 2) begin
            while (pending_rows.size() != 0) @(negedge clock);
         end
      end
      drain_rows();
   endtask

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // compare each row transaction with the oldest queued expectation
   always @(posedge clock) begin
      screen_row_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rows.size() == 0) begin
            $display("%0t: unexpected row transaction row=%0d glyph=%0d last=%0b",
                     $realtime, rsp_tdata[5:0], rsp_tdata[9:6], rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_rows.pop_front();
            if (rsp_tdata[5:0] !== want.row) begin
               $display("%0t: row expected %0d actual %0d",
                        $realtime, want.row, rsp_tdata[5:0]);
               mismatch_count++;
            end
            if (rsp_tdata[9:6] !== want.glyph) begin
               $display("%0t: glyph of row %0d expected %0d actual %0d",
                        $realtime, want.row, want.glyph, rsp_tdata[9:6]);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last_row) begin
               $display("%0t: last flag of row %0d expected %0b actual %0b",
                        $realtime, want.row, want.last_row, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      mismatch_count    = 0;
      cycle_count       = 0;
      sender_idle_pct   = 11;
      receiver_idle_pct = 52;
      rsp_tready        = 1'b0;
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      csr_we            = 1'b0;
      csr_addr          = REG_WALL_A;
      csr_wdata         = '0;
      for (int i = 0; i < 4; i++) wall_map[i] = '0;
      shadow_view_w = 120;
      shadow_view_h = 40;
      shadow_fov    = 8192;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_open_map();
      test_walled_room();
      test_register_extremes();
      test_random_views(11, 52);
      test_random_views(52, 11);
      test_random_views(0, 0);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
